[src/fldx_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fldx_pkg: shared types and constants for the single-precision ldexp block.
// Holds the field masks, exponent limits and the decoded operand struct.
// ----------------------------------------------------------------------------
package fldx_pkg;

    localparam logic [31:0] SIGN_MASK  = 32'h8000_0000;
    localparam logic [31:0] INF_BITS   = 32'h7f80_0000;
    localparam int          EXP_BIAS   = 127;
    localparam int          EXP_MIN    = -126;
    localparam int          SCALE_LIM  = 512;

    // Decoded operand, passed from the decode stage to the pack stage.
    typedef struct packed {
        logic              pass;   // operand is zero, infinity or NaN
        logic              sign;
        logic [23:0]       sig;    // normalised significand, bit 23 set
        logic signed [10:0] adj;   // unbiased exponent after scaling
        logic [31:0]       raw;
    } fldx_dec_t;

endpackage

[src/fldx_decode.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fldx_decode: splits the operand, normalises a subnormal and adds the
// clamped scale to the unbiased exponent.
// ----------------------------------------------------------------------------
module fldx_decode
    import fldx_pkg::*;
(
    input  logic [31:0]        value_bits,
    input  logic signed [31:0] scale_exponent,
    output fldx_dec_t          dec
);

    logic [7:0]         bexp;
    logic [22:0]        frac;
    logic [4:0]         lz;
    logic [23:0]        sig;
    logic signed [10:0] unb;
    logic signed [10:0] scl;
    logic               found;

    assign bexp = value_bits[30:23];
    assign frac = value_bits[22:0];

    // Leading-zero count over the 23-bit fraction (independent bit tests).
    always_comb
    begin
        lz    = 5'd22;
        found = 1'b0;
        for (int i = 22; i >= 0; i--)
        begin
            if (!found && frac[i])
            begin
                lz    = 5'(22 - i);
                found = 1'b1;
            end
        end
    end

    always_comb
    begin
        if (bexp == 8'd0)
        begin
            sig = {1'b0, frac} << (lz + 5'd1);
            unb = 11'(EXP_MIN) - 11'(lz) - 11'sd1;
        end
        else
        begin
            sig = {1'b1, frac};
            unb = 11'($signed({3'b000, bexp})) - 11'(EXP_BIAS);
        end
        if (scale_exponent < -32'sd512)
            scl = -11'(SCALE_LIM);
        else if (scale_exponent > 32'sd512)
            scl = 11'(SCALE_LIM);
        else
            scl = scale_exponent[10:0];
    end

    assign dec.pass = (bexp == 8'hff) || (value_bits[30:0] == 31'd0);
    assign dec.sign = value_bits[31];
    assign dec.sig  = sig;
    assign dec.adj  = unb + scl;
    assign dec.raw  = value_bits;

endmodule

[src/fldx_pack.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fldx_pack: repacks the scaled operand as a normal, rounded subnormal,
// signed zero or signed infinity, or passes a zero, infinity or NaN through.
// ----------------------------------------------------------------------------
module fldx_pack
    import fldx_pkg::*;
(
    input  fldx_dec_t   dec,
    output logic [31:0] result_bits
);

    logic signed [10:0] sh;
    logic [4:0]         s;
    logic [23:0]        trunc;
    logic [23:0]        rem;
    logic [23:0]        half;
    logic               up;
    logic [31:0]        sgn;
    logic [7:0]         be;

    assign sgn   = dec.sign ? SIGN_MASK : 32'd0;
    assign sh    = 11'(EXP_MIN) - dec.adj;
    assign s     = sh[4:0];
    assign trunc = dec.sig >> s;
    assign rem   = dec.sig & ((24'd1 << s) - 24'd1);
    assign half  = 24'd1 << (s - 5'd1);
    assign up    = (rem > half) || ((rem == half) && trunc[0]);
    assign be    = 8'(dec.adj + 11'(EXP_BIAS));

    always_comb
    begin
        if (dec.pass)
            result_bits = dec.raw;
        else if (dec.adj > 11'(EXP_BIAS))
            result_bits = sgn | INF_BITS;
        else if (dec.adj < 11'(EXP_MIN))
        begin
            if (sh >= 11'sd25)
                result_bits = sgn;
            else
                result_bits = sgn | {8'd0, trunc + {23'd0, up}};
        end
        else
            result_bits = sgn | {1'b0, be, dec.sig[22:0]};
    end

endmodule

[src/float32_ldexp_scale_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// float32_ldexp_scale_top: single-precision scale by a power of two.
// Decode and pack logic on the accepted input item, feeding a result register.
// ----------------------------------------------------------------------------
// Usage: an item on the input channel carries value_bits and scale_exponent
// and is taken at a rising edge with in_valid high and in_stall low. Its
// result appears in the output register in the next cycle, when out_valid
// rises. The block takes one item every cycle while in_stall is low; the
// rate is set by the single pass of decode and pack logic between the
// input handshake and the result register.
// When the receiver raises out_stall the result register holds its item,
// and in_stall follows out_stall only while that register is full, so a
// new item is still taken whenever the held result is being delivered or
// the register is empty. Reset clears the valid flag of the result
// register; no item is in flight afterwards.
// Results are exact IEEE bit patterns, subnormals rounded to nearest even.
// ----------------------------------------------------------------------------
module float32_ldexp_scale_top
    import fldx_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [31:0]        value_bits,
    input  logic signed [31:0] scale_exponent,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [31:0]        result_bits
);

    fldx_dec_t   dec;
    logic [31:0] res_next;
    logic [31:0] res_reg;
    logic        vld_reg;
    logic        vld_next;
    logic        take;

    fldx_decode u_decode
    (
        .value_bits     (value_bits),
        .scale_exponent (scale_exponent),
        .dec            (dec)
    );

    fldx_pack u_pack
    (
        .dec         (dec),
        .result_bits (res_next)
    );

    // The result register is free when empty or when its item leaves now.
    assign in_stall = vld_reg && out_stall;
    assign take     = in_valid && !in_stall;
    assign vld_next = take || (vld_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            res_reg <= res_next;
    end

    assign out_valid   = vld_reg;
    assign result_bits = res_reg;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg && out_stall |=> vld_reg && $stable(res_reg))
        else $error("held result changed");
    a_load: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> vld_reg)
        else $error("accepted item lost");
    a_nostall: assert property (@(posedge clk) disable iff (!rst_n)
        !vld_reg |-> !in_stall)
        else $error("stall while empty");

endmodule
